// ----- rtl/srng_pkg.sv -----
// Shared types, constants and helper functions for the shuffled Lehmer generator.
package srng_pkg;

    // Generator constants.
    localparam logic [14:0] LCG_MULT    = 15'd16807;
    localparam logic [30:0] LCG_MOD     = 31'h7FFF_FFFF;
    localparam logic [30:0] SEED_SMALL  = 31'd1000;
    localparam logic [30:0] SEED_BOOST  = 31'd22261048;
    localparam logic [31:0] MAX_SPAN_M1 = 32'h7FFF_FFFF;
    localparam logic [31:0] SPAN_LIMIT  = 32'h8000_0000;

    // Item kinds.
    typedef enum logic [1:0] {
        KIND_RESEED  = 2'd0,
        KIND_RAW     = 2'd1,
        KIND_BOUNDED = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    // Request into the shared divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic        done;
        logic [31:0] rem;
    } div_rsp_t;

    // Seed conditioning: boost small seeds, and map the modulus itself to one.
    function automatic logic [30:0] seed_fix(input logic [30:0] s);
        logic [30:0] t;
        begin
            t = (s < SEED_SMALL) ? (s + SEED_BOOST) : s;
            if (t == LCG_MOD)
            begin
                t = 31'd1;
            end
            return t;
        end
    endfunction

    // Reduce a 46-bit product modulo 2^31 - 1 by folding the high part onto the low part.
    function automatic logic [30:0] lehmer_fold(input logic [45:0] p);
        logic [31:0] sum;
        begin
            sum = {1'b0, p[30:0]} + {17'd0, p[45:31]};
            if (sum >= {1'b0, LCG_MOD})
            begin
                sum = sum - {1'b0, LCG_MOD};
            end
            return sum[30:0];
        end
    endfunction

endpackage

// ----- rtl/srng_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module srng_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/srng_lehmer.sv -----
// Two-stage Lehmer step unit: registered multiply by 16807, then fold modulo 2^31 - 1.
module srng_lehmer (
    input  logic        clk,
    input  logic [30:0] x,
    output logic [30:0] y
);
    import srng_pkg::*;

    logic [45:0] prod_reg;
    logic [45:0] prod_next;

    // The product of the current state and the multiplier is taken every cycle.
    assign prod_next = {15'd0, x} * {31'd0, LCG_MULT};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // The fold and one conditional subtract give the exact residue.
    assign y = lehmer_fold(prod_reg);

endmodule

// ----- rtl/srng_div.sv -----
// Shared restoring divider: one remainder bit per cycle over all 32 dividend bits.
module srng_div (
    input  logic                clk,
    input  logic                rst_n,
    input  srng_pkg::div_req_t  req,
    output srng_pkg::div_rsp_t  rsp
);
    import srng_pkg::*;

    localparam int FULL_BITS = 32;

    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [5:0]  cnt_reg;
    logic [5:0]  cnt_next;
    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] dvd_reg;
    logic [31:0] dvd_next;
    logic [31:0] dvs_reg;
    logic [31:0] dvs_next;

    logic [32:0] trial;
    logic [32:0] diff;
    logic        fits;

    // One trial subtraction of the divisor from the shifted partial remainder.
    assign trial = {rem_reg, dvd_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            dvs_next  = req.divisor;
            cnt_next  = 6'(FULL_BITS);
            rem_next  = '0;
            dvd_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[31:0] : trial[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- rtl/shuffled_park_miller_rng_top.sv -----
// Top level of the shuffled minimal-standard Lehmer generator with its sequencer.
//
//   Channel   Handshake                Payload
//   input     in_valid / in_stall      kind, range_low, range_high
//   output    out_valid / out_stall    value
//   config    cfg_valid / cfg_ready    seed_value
//
// With N = TABLE_SIZE, one generator step plus table swap passes through S_STEP_MUL, S_STEP_FOLD,
// S_SLOT_DIV, S_TBL_RD and S_TBL_SWAP; a raw draw then passes S_RESULT before the next transfer.
// A reseed runs N + 8 steps of the Lehmer unit, of which the last N fill the table.
// A bounded draw adds two passes of the shared divider plus one step per rejection.
// The first draw after reset also runs the table fill, N + 8 Lehmer steps.
// The result waits in an output register, so a stalled output holds back only the next result.
module shuffled_park_miller_rng_top #(
    parameter int TABLE_SIZE = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic signed [31:0] range_low,
    input  logic signed [31:0] range_high,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        seed_value
);
    import srng_pkg::*;

    localparam int AW        = $clog2(TABLE_SIZE);
    localparam int CW        = $clog2(TABLE_SIZE + 8);
    localparam int QW        = $clog2(TABLE_SIZE + 1);
    localparam int INIT_LAST = TABLE_SIZE + 7;
    localparam longint unsigned SLOT_DIV = 1 + (64'd2147483646 / TABLE_SIZE);
    localparam logic [30:0]   SLOT_D   = SLOT_DIV[30:0];
    localparam logic [QW-1:0] SLOT_RCP = QW'(64'h8000_0000 / SLOT_DIV);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_INIT_MUL  = 11'b000_0000_0010,
        S_INIT_FOLD = 11'b000_0000_0100,
        S_STEP_MUL  = 11'b000_0000_1000,
        S_STEP_FOLD = 11'b000_0001_0000,
        S_SLOT_DIV  = 11'b000_0010_0000,
        S_TBL_RD    = 11'b000_0100_0000,
        S_TBL_SWAP  = 11'b000_1000_0000,
        S_LIM_DIV   = 11'b001_0000_0000,
        S_MOD_DIV   = 11'b010_0000_0000,
        S_RESULT    = 11'b100_0000_0000
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    logic [30:0]   seed_reg;
    logic [30:0]   seed_next;
    logic [30:0]   gen_reg;
    logic [30:0]   gen_next;
    logic [30:0]   shuf_reg;
    logic [30:0]   shuf_next;
    kind_t         kind_reg;
    kind_t         kind_next;
    logic [31:0]   lo_reg;
    logic [31:0]   lo_next;
    logic [31:0]   span_reg;
    logic [31:0]   span_next;
    logic [31:0]   limit_reg;
    logic [31:0]   limit_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [AW-1:0] slot_reg;
    logic [AW-1:0] slot_next;
    logic [QW-1:0] slot_q0_reg;
    logic [QW-1:0] slot_q0_next;
    logic [30:0]   slot_back_reg;
    logic [30:0]   slot_back_next;
    logic [31:0]   res_reg;
    logic [31:0]   res_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [31:0]   value_reg;
    logic [31:0]   value_next;

    logic [30:0]   step_val;
    div_req_t      div_req;
    div_rsp_t      div_rsp;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [30:0]   ram_wdata;
    logic          ram_re;
    logic [30:0]   ram_rdata;

    logic [31:0]    span_in;
    logic           span_bad;
    logic           need_init;
    state_t         draw_state;
    logic [30:0]    draw_gen;
    logic [30+QW:0] rcp_prod;
    logic [30+QW:0] back_prod;
    logic [30:0]    slot_rem;
    logic [QW-1:0]  slot_q;
    logic [AW-1:0]  slot_clamped;
    logic           out_free;

    // Shared Lehmer step unit, always fed with the current generator state.
    srng_lehmer u_lehmer (
        .clk (clk),
        .x   (gen_reg),
        .y   (step_val)
    );

    // Shared divider for the rejection limit and the final modulo.
    srng_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shuffle table.
    srng_ram #(
        .WIDTH (31),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Span of a bounded draw, wrapped to 32 bits; zero or above 2^31 means no draw.
    assign span_in  = 32'(range_high) - 32'(range_low) + 32'd1;
    assign span_bad = (span_in == 32'd0) || (span_in > SPAN_LIMIT);

    // A draw first fills the table when the generator was never seeded.
    assign need_init  = (gen_reg == 31'd0) || (shuf_reg == 31'd0);
    assign draw_state = need_init ? S_INIT_MUL : S_STEP_MUL;
    assign draw_gen   = need_init ? seed_fix((gen_reg != 31'd0) ? gen_reg : 31'd1) : gen_reg;

    // Slot index by reciprocal multiplication: the estimate is exact or one low,
    // and a compare of the remainder against the slot width fixes it.
    assign rcp_prod       = {{QW{1'b0}}, shuf_reg} * {31'd0, SLOT_RCP};
    assign slot_q0_next   = rcp_prod[30+QW:31];
    assign back_prod      = {31'd0, slot_q0_reg} * {{QW{1'b0}}, SLOT_D};
    assign slot_back_next = back_prod[30:0];
    assign slot_rem       = shuf_reg - slot_back_reg;
    assign slot_q         = slot_q0_reg + QW'(slot_rem >= SLOT_D);

    // Slot index clamped to the last entry.
    assign slot_clamped = (slot_q >= QW'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) : slot_q[AW-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = cfg_valid ? seed_value : seed_reg;
        gen_next       = gen_reg;
        shuf_next      = shuf_reg;
        kind_next      = kind_reg;
        lo_next        = lo_reg;
        span_next      = span_reg;
        limit_next     = limit_reg;
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        value_next     = value_reg;
        div_req        = '0;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[AW-1:0];
        ram_wdata      = step_val;
        ram_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind_t'(kind);
                    lo_next   = 32'(range_low);
                    span_next = span_in;
                    case (kind_t'(kind))
                        KIND_RESEED:
                        begin
                            gen_next   = seed_fix(seed_reg);
                            cnt_next   = CW'(INIT_LAST);
                            state_next = S_INIT_MUL;
                        end
                        KIND_RAW:
                        begin
                            gen_next   = draw_gen;
                            cnt_next   = CW'(INIT_LAST);
                            state_next = draw_state;
                        end
                        KIND_BOUNDED:
                        begin
                            if (span_bad)
                            begin
                                res_next   = 32'(range_low);
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = SPAN_LIMIT;
                                div_req.divisor  = span_in;
                                state_next       = S_LIM_DIV;
                            end
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_INIT_MUL:
            begin
                state_next = S_INIT_FOLD;
            end

            S_INIT_FOLD:
            begin
                // The last TABLE_SIZE steps fill the table from the top entry down.
                gen_next = step_val;
                ram_we   = (cnt_reg < CW'(TABLE_SIZE));
                if (cnt_reg == '0)
                begin
                    shuf_next = step_val;
                    if (kind_reg == KIND_RESEED)
                    begin
                        res_next   = '0;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_STEP_MUL;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_INIT_MUL;
                end
            end

            S_STEP_MUL:
            begin
                state_next = S_STEP_FOLD;
            end

            S_STEP_FOLD:
            begin
                gen_next   = step_val;
                state_next = S_SLOT_DIV;
            end

            S_SLOT_DIV:
            begin
                slot_next  = slot_clamped;
                state_next = S_TBL_RD;
            end

            S_TBL_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_TBL_SWAP;
            end

            S_TBL_SWAP:
            begin
                // The selected entry becomes the output and takes the fresh generator value.
                shuf_next = ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = slot_reg;
                ram_wdata = gen_reg;
                if (kind_reg == KIND_RAW)
                begin
                    res_next   = {1'b0, ram_rdata};
                    state_next = S_RESULT;
                end
                else if ({1'b0, ram_rdata} > limit_reg)
                begin
                    state_next = S_STEP_MUL;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, ram_rdata};
                    div_req.divisor  = span_reg;
                    state_next       = S_MOD_DIV;
                end
            end

            S_LIM_DIV:
            begin
                if (div_rsp.done)
                begin
                    limit_next = MAX_SPAN_M1 - div_rsp.rem;
                    gen_next   = draw_gen;
                    cnt_next   = CW'(INIT_LAST);
                    state_next = draw_state;
                end
            end

            S_MOD_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = lo_reg + div_rsp.rem;
                    state_next = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and generator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= 31'd1;
            gen_reg       <= '0;
            shuf_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            gen_reg       <= gen_next;
            shuf_reg      <= shuf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item payload and working registers.
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        lo_reg        <= lo_next;
        span_reg      <= span_next;
        limit_reg     <= limit_next;
        cnt_reg       <= cnt_next;
        slot_reg      <= slot_next;
        slot_q0_reg   <= slot_q0_next;
        slot_back_reg <= slot_back_next;
        res_reg       <= res_next;
        value_reg     <= value_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign value     = signed'(value_reg);

endmodule

// ----- rtl/srng_checker.sv -----
// Port-level assertions for the shuffled Lehmer generator, bound to its top level.
module srng_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] value
);

    // A stalled result stays offered with the same value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(value)))
    else $error("stalled result changed or dropped");

    // The block works on one item at a time: a transfer in closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input open in the cycle after a transfer");

    // A new result appears only while an item was in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

    // The input never opens while the previous item could still be loading its result
    // into a full, stalled output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($fell(in_stall) && $past(out_valid) && $past(out_stall)) |-> out_valid)
    else $error("pending result lost when the input reopened");

endmodule

bind shuffled_park_miller_rng_top srng_checker u_srng_checker (.*);
